[design/ctcm_pkg.sv]
// ----------------------------------------------------------------------------
// ctcm_pkg
// Shared types and constants for the code to CID / Unicode table block.
// ----------------------------------------------------------------------------
package ctcm_pkg;

    // operation codes
    localparam logic [1:0] OP_ADD_RANGE   = 2'd0;
    localparam logic [1:0] OP_SET_UNICODE = 2'd1;
    localparam logic [1:0] OP_LOOKUP      = 2'd2;

    // table clear values
    localparam logic [15:0] CID_CLEAR    = 16'h0000;
    localparam logic [15:0] SQUARE_GLYPH = 16'h25A1;

    // request word
    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] code;
        logic [15:0] range_last;
        logic [15:0] cid_start;
        logic [15:0] unicode_value;
    } t_req;

    // response word
    typedef struct packed {
        logic [15:0] cid_value;
        logic [15:0] unicode_out;
    } t_rsp;

    // memory strobes from the sequencer
    typedef struct packed {
        logic cid_we;
        logic uni_we;
        logic rd_en;
    } t_mem_ctl;

    // sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_FILL
    } t_state;

endpackage

[design/ctcm_ram.sv]
// ----------------------------------------------------------------------------
// ctcm_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ctcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/ctcm_ctrl.sv]
// ----------------------------------------------------------------------------
// ctcm_ctrl
// Sequencer: clearing pass, range fill, single writes and lookup reads.
// ----------------------------------------------------------------------------
module ctcm_ctrl #(
    parameter int CODE_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  ctcm_pkg::t_req            i_req,
    output ctcm_pkg::t_mem_ctl        o_ctl,
    output logic [CODE_BITS-1:0]      o_waddr,
    output logic [CODE_BITS-1:0]      o_raddr,
    output logic [15:0]               o_cid_wdata,
    output logic [15:0]               o_uni_wdata,
    output logic                      o_valid
);
    import ctcm_pkg::*;

    localparam logic [CODE_BITS-1:0] ADDR_ONE  = CODE_BITS'(1);
    localparam logic [CODE_BITS-1:0] ADDR_LAST = {CODE_BITS{1'b1}};

    t_state               r_state, n_state;
    logic [CODE_BITS-1:0] r_addr,  n_addr;
    logic [CODE_BITS-1:0] r_last,  n_last;
    logic [15:0]          r_cid,   n_cid;

    logic                 accept;
    logic [CODE_BITS-1:0] req_code;
    logic [CODE_BITS-1:0] req_last;
    logic                 range_empty;

    // request decode, codes cut to the table width
    assign busy        = (r_state == ST_CLEAR) || (r_state == ST_FILL);
    assign accept      = start && !busy;
    assign req_code    = i_req.code[CODE_BITS-1:0];
    assign req_last    = i_req.range_last[CODE_BITS-1:0];
    assign range_empty = req_last < req_code;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_addr == ADDR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE, ST_LOOK: begin
                n_state = ST_IDLE;
                if (accept) begin
                    case (i_req.operation)
                        OP_ADD_RANGE: n_state = range_empty ? ST_IDLE : ST_FILL;
                        OP_LOOKUP:    n_state = ST_LOOK;
                        default:      n_state = ST_IDLE;
                    endcase
                end
            end
            ST_FILL: begin
                if (r_addr == r_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // memory strobes, addresses and write data
    always_comb begin
        o_ctl       = '0;
        o_waddr     = r_addr;
        o_raddr     = req_code;
        o_cid_wdata = r_cid;
        o_uni_wdata = i_req.unicode_value;
        unique case (r_state)
            ST_CLEAR: begin
                o_ctl.cid_we = 1'b1;
                o_ctl.uni_we = 1'b1;
                o_cid_wdata  = CID_CLEAR;
                o_uni_wdata  = SQUARE_GLYPH;
            end
            ST_IDLE, ST_LOOK: begin
                if (accept) begin
                    case (i_req.operation)
                        OP_SET_UNICODE: begin
                            o_ctl.uni_we = 1'b1;
                            o_waddr      = req_code;
                        end
                        OP_LOOKUP: o_ctl.rd_en = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_FILL: o_ctl.cid_we = 1'b1;
            default: ;
        endcase
    end

    // result strobe: read data is valid the cycle after the lookup
    assign o_valid = (r_state == ST_LOOK);

    // counters for the clearing pass and the range fill
    always_comb begin
        n_addr = r_addr;
        n_last = r_last;
        n_cid  = r_cid;
        if ((r_state == ST_CLEAR) || (r_state == ST_FILL)) begin
            n_addr = r_addr + ADDR_ONE;
            n_cid  = r_cid + 16'd1;
        end else if (accept && (i_req.operation == OP_ADD_RANGE)) begin
            n_addr = req_code;
            n_last = req_last;
            n_cid  = i_req.cid_start;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    // fill payload registers
    always_ff @(posedge i_clk) begin
        r_last <= n_last;
        r_cid  <= n_cid;
    end

endmodule

[design/code_to_cid_range_map.sv]
// ----------------------------------------------------------------------------
// code_to_cid_range_map
// Character code to CID and Unicode tables, with range fill and lookup.
// ----------------------------------------------------------------------------
//  channel   | handshake           | word
//  ----------+---------------------+---------------------------------------
//  request   | start / busy        | i_req  (operation, code, range ...)
//  response  | o_valid strobe      | o_rsp  (cid_value, unicode_out)
//
//  Lookup: the response strobes the cycle after the request; a new request
//  is taken in that same cycle. A set Unicode request leaves busy low.
//  A range fill holds busy while it writes one code per cycle through the
//  CID memory write port; an empty range leaves busy low. After reset a
//  clearing pass over all 2**CODE_BITS codes (65536 at default) holds busy
//  high. The receiver cannot stall; responses are never held.
// ----------------------------------------------------------------------------
module code_to_cid_range_map #(
    parameter int CODE_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ctcm_pkg::t_req i_req,
    output logic           o_valid,
    output ctcm_pkg::t_rsp o_rsp
);
    import ctcm_pkg::*;

    localparam int DEPTH = 2 ** CODE_BITS;

    t_mem_ctl             ctl;
    logic [CODE_BITS-1:0] waddr;
    logic [CODE_BITS-1:0] raddr;
    logic [15:0]          cid_wdata;
    logic [15:0]          uni_wdata;
    logic [15:0]          cid_rdata;
    logic [15:0]          uni_rdata;

    // sequencer
    ctcm_ctrl #(
        .CODE_BITS (CODE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_ctl       (ctl),
        .o_waddr     (waddr),
        .o_raddr     (raddr),
        .o_cid_wdata (cid_wdata),
        .o_uni_wdata (uni_wdata),
        .o_valid     (o_valid)
    );

    // cid table
    ctcm_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_cid_ram (
        .i_clk   (i_clk),
        .i_we    (ctl.cid_we),
        .i_waddr (waddr),
        .i_wdata (cid_wdata),
        .i_re    (ctl.rd_en),
        .i_raddr (raddr),
        .o_rdata (cid_rdata)
    );

    // unicode table
    ctcm_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_uni_ram (
        .i_clk   (i_clk),
        .i_we    (ctl.uni_we),
        .i_waddr (waddr),
        .i_wdata (uni_wdata),
        .i_re    (ctl.rd_en),
        .i_raddr (raddr),
        .o_rdata (uni_rdata)
    );

    // response word straight from the registered read data
    assign o_rsp.cid_value   = cid_rdata;
    assign o_rsp.unicode_out = uni_rdata;

endmodule

[design/ctcm_checker.sv]
// ----------------------------------------------------------------------------
// ctcm_checker
// Port level checks for the code to CID table block, bound to the top level.
// ----------------------------------------------------------------------------
module ctcm_checker #(
    parameter int CODE_BITS = 16
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input ctcm_pkg::t_req i_req,
    input logic           o_valid
);
    import ctcm_pkg::*;

    logic take_lookup;
    logic take_fill;

    assign take_lookup = start && !busy && (i_req.operation == OP_LOOKUP);
    assign take_fill   = start && !busy && (i_req.operation == OP_ADD_RANGE) &&
                         (i_req.range_last[CODE_BITS-1:0] >= i_req.code[CODE_BITS-1:0]);

    // every taken lookup gives a response next cycle
    a_lookup_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_lookup |=> o_valid)
        else $error("lookup gave no response");

    // no response without a lookup the cycle before
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(take_lookup))
        else $error("response without lookup");

    // clearing pass runs after reset
    a_clear_busy: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> busy)
        else $error("not busy after reset");

    // a non-empty range fill holds busy
    a_fill_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_fill |=> busy && !o_valid)
        else $error("range fill not busy");

endmodule

bind code_to_cid_range_map ctcm_checker #(
    .CODE_BITS (CODE_BITS)
) u_ctcm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_valid (o_valid)
);
